/* rtl/sclm_pkg.sv */
// ----------------------------------------------------------------------------
// sclm_pkg
// Shared types and constants for the serial command line matcher.
// ----------------------------------------------------------------------------
package sclm_pkg;

    // Default parameter values
    localparam int BUF_LEN_DEF      = 32;
    localparam int NAME_LEN_DEF     = 8;
    localparam int MAX_COMMANDS_DEF = 7;

    // Fixed by the register map and field widths
    localparam int WORD_SLOTS  = 7;
    localparam int HEAD_BYTES  = 8;
    localparam int CFG_ADDR_W  = 6;
    localparam int CFG_DATA_W  = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;

    // Register indexes (paddr[5:3])
    localparam logic [2:0] REG_COUNT = 3'd0;
    localparam logic [2:0] REG_WORD0 = 3'd1;

    typedef enum logic [1:0] {
        OUT_BLANK   = 2'd0,
        OUT_MATCH   = 2'd1,
        OUT_NOMATCH = 2'd2
    } outcome_t;

    // One finished line, handed from front to back
    typedef struct packed {
        logic        blank;
        logic [63:0] head_chars;
        logic [5:0]  head_length;
    } line_rec_t;

    // Configuration seen by the back end
    typedef struct packed {
        logic [2:0]                  count;
        logic [WORD_SLOTS-1:0][63:0] words;
    } cfg_t;

endpackage

/* rtl/sclm_regs.sv */
// ----------------------------------------------------------------------------
// sclm_regs
// APB register file: command count and command words.
// ----------------------------------------------------------------------------
module sclm_regs
    import sclm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [2:0]                  count_reg;
    logic [WORD_SLOTS-1:0][63:0] words_reg;
    logic [2:0]                  reg_idx;
    logic [2:0]                  word_idx;
    logic                        wr_en;

    assign pready   = 1'b1;
    assign reg_idx  = paddr[5:3];
    assign word_idx = reg_idx - REG_WORD0;
    assign wr_en    = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            words_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_COUNT:
                begin
                    count_reg <= pwdata[2:0];
                end
                default:
                begin
                    words_reg[word_idx] <= pwdata;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_COUNT:
            begin
                prdata = {{(CFG_DATA_W-3){1'b0}}, count_reg};
            end
            default:
            begin
                prdata = words_reg[word_idx];
            end
        endcase
    end

    assign cfg.count = count_reg;
    assign cfg.words = words_reg;

endmodule

/* rtl/sclm_front.sv */
// ----------------------------------------------------------------------------
// sclm_front
// Line tracker: classifies each byte and follows the first token.
// ----------------------------------------------------------------------------
module sclm_front
    import sclm_pkg::*;
#(
    parameter int BUF_LEN = BUF_LEN_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  logic [7:0] in_byte,
    output logic      push,
    output line_rec_t push_rec
);

    typedef enum logic [2:0] {
        PH_BEFORE = 3'b001,
        PH_INSIDE = 3'b010,
        PH_AFTER  = 3'b100
    } phase_t;

    phase_t      phase_reg,  phase_next;
    logic [5:0]  held_reg,   held_next;
    logic [63:0] chars_reg,  chars_next;
    logic [5:0]  len_reg,    len_next;
    logic        accept;
    logic        is_nl;
    logic        printable;
    logic        take_char;

    assign accept    = in_valid && in_ready;
    assign is_nl     = (in_byte == CHAR_NL);
    assign printable = (in_byte >= CHAR_SPACE) && (in_byte <= CHAR_TILDE);

    assign push                 = accept && is_nl;
    assign push_rec.blank       = (phase_reg == PH_BEFORE);
    assign push_rec.head_chars  = chars_reg;
    assign push_rec.head_length = len_reg;

    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        chars_next = chars_reg;
        len_next   = len_reg;
        take_char  = 1'b0;
        if (accept && is_nl)
        begin
            phase_next = PH_BEFORE;
            held_next  = '0;
            chars_next = '0;
            len_next   = '0;
        end
        else if (accept && printable && (held_reg < 6'(BUF_LEN)))
        begin
            held_next = held_reg + 6'd1;
            unique case (phase_reg)
                PH_BEFORE:
                begin
                    if (in_byte != CHAR_SPACE)
                    begin
                        phase_next = PH_INSIDE;
                        take_char  = 1'b1;
                    end
                end
                PH_INSIDE:
                begin
                    if (in_byte == CHAR_SPACE)
                    begin
                        phase_next = PH_AFTER;
                    end
                    else
                    begin
                        take_char = 1'b1;
                    end
                end
                PH_AFTER:
                begin
                    phase_next = PH_AFTER;
                end
                default:
                begin
                    phase_next = PH_BEFORE;
                end
            endcase
            if (take_char)
            begin
                len_next = len_reg + 6'd1;
                for (int k = 0; k < HEAD_BYTES; k++)
                begin
                    if (len_reg == 6'(k))
                    begin
                        chars_next[8*k +: 8] = in_byte;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_BEFORE;
            held_reg  <= '0;
            chars_reg <= '0;
            len_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            chars_reg <= chars_next;
            len_reg   <= len_next;
        end
    end

endmodule

/* rtl/sclm_queue.sv */
// ----------------------------------------------------------------------------
// sclm_queue
// Short FIFO of finished lines between front and back.
// ----------------------------------------------------------------------------
module sclm_queue
    import sclm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  line_rec_t push_rec,
    input  logic      pop,
    output logic      full,
    output logic      not_empty,
    output line_rec_t head_rec
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    line_rec_t              mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   do_push;
    logic                   do_pop;

    assign full      = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head_rec  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/sclm_back.sv */
// ----------------------------------------------------------------------------
// sclm_back
// Compares a finished line against the command words; output register.
// ----------------------------------------------------------------------------
module sclm_back
    import sclm_pkg::*;
#(
    parameter int NAME_LEN     = NAME_LEN_DEF,
    parameter int MAX_COMMANDS = MAX_COMMANDS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      rec_valid,
    input  line_rec_t rec,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output outcome_t  outcome,
    output logic [2:0]  match_index,
    output logic [63:0] token_head,
    output logic [5:0]  token_length
);

    // Byte-wise compare, ends equal at the first NUL in the token
    function automatic logic word_match(input logic [63:0] head, input logic [63:0] word);
        logic ok;
        logic done;
        ok   = 1'b1;
        done = 1'b0;
        for (int k = 0; k < HEAD_BYTES; k++)
        begin
            if ((k < NAME_LEN) && !done)
            begin
                if (head[8*k +: 8] != word[8*k +: 8])
                begin
                    ok   = 1'b0;
                    done = 1'b1;
                end
                else if (head[8*k +: 8] == 8'h00)
                begin
                    done = 1'b1;
                end
            end
        end
        return ok;
    endfunction

    logic        valid_reg;
    outcome_t    outcome_reg;
    logic [2:0]  index_reg;
    logic [63:0] head_reg;
    logic [5:0]  len_reg;

    logic [2:0]  limit;
    logic        found;
    logic [2:0]  found_idx;

    assign pop = rec_valid && (!valid_reg || out_ready);

    always_comb
    begin
        limit = (cfg.count > 3'(MAX_COMMANDS)) ? 3'(MAX_COMMANDS) : cfg.count;
        found     = 1'b0;
        found_idx = '0;
        // walk down so the lowest index wins
        for (int i = WORD_SLOTS - 1; i >= 0; i--)
        begin
            if ((3'(i) < limit) && word_match(rec.head_chars, cfg.words[i]))
            begin
                found     = 1'b1;
                found_idx = 3'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (rec.blank)
            begin
                outcome_reg <= OUT_BLANK;
                index_reg   <= '0;
                head_reg    <= '0;
                len_reg     <= '0;
            end
            else
            begin
                outcome_reg <= found ? OUT_MATCH : OUT_NOMATCH;
                index_reg   <= found ? found_idx : 3'd0;
                head_reg    <= rec.head_chars;
                len_reg     <= rec.head_length;
            end
        end
    end

    assign out_valid    = valid_reg;
    assign outcome      = outcome_reg;
    assign match_index  = index_reg;
    assign token_head   = head_reg;
    assign token_length = len_reg;

endmodule

/* rtl/serial_command_line_matcher.sv */
// ----------------------------------------------------------------------------
// serial_command_line_matcher
// Collects received bytes into a line and matches its first token against
// up to seven configured command words.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one received byte per item. Printable bytes build the
//   line (at most BUF_LEN held, the rest dropped); other bytes are ignored.
//   A newline byte closes the line and yields one result item on m_axis:
//   tuser = outcome (blank / matched / unmatched), tdata = match index,
//   first eight token characters and token length. No other byte yields
//   a result.
//   Throughput: one byte per cycle while the line queue is not full. The
//   line tracker finishes a line in the cycle its newline is taken; the
//   compare of all command words is combinational in the back end.
//   Path: a result is registered in the line queue, then in the output
//   register, before it is offered on m_axis.
//   Stall: a stalled m_axis holds the result; finished lines wait in a
//   two-entry queue, and s_axis_tready drops only while that queue is full.
//   Reset: clears the line, queue, output valid and all config registers (no commands).
//   Config: APB, 64-bit data, register i at byte address 8*i; write only
//   while no line is in flight.
// ----------------------------------------------------------------------------
module serial_command_line_matcher
    import sclm_pkg::*;
#(
    parameter int BUF_LEN      = BUF_LEN_DEF,
    parameter int NAME_LEN     = NAME_LEN_DEF,
    parameter int MAX_COMMANDS = MAX_COMMANDS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // APB configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    // byte input
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] rx_byte
    // result output
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [79:0]           m_axis_tdata,   // [2:0] match_index,
                                                  // [66:3] token_head,
                                                  // [72:67] token_length,
                                                  // [79:73] zero
    output logic [1:0]            m_axis_tuser    // [1:0] outcome
);

    cfg_t        cfg;
    logic        push;
    line_rec_t   push_rec;
    logic        q_full;
    logic        q_valid;
    line_rec_t   q_rec;
    logic        pop;
    outcome_t    outcome;
    logic [2:0]  match_index;
    logic [63:0] token_head;
    logic [5:0]  token_length;

    // only a newline needs queue space, but stall all bytes to keep order
    assign s_axis_tready = !q_full;

    sclm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sclm_front #(
        .BUF_LEN (BUF_LEN)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .push     (push),
        .push_rec (push_rec)
    );

    sclm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_rec  (push_rec),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head_rec  (q_rec)
    );

    sclm_back #(
        .NAME_LEN     (NAME_LEN),
        .MAX_COMMANDS (MAX_COMMANDS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .rec_valid    (q_valid),
        .rec          (q_rec),
        .pop          (pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .outcome      (outcome),
        .match_index  (match_index),
        .token_head   (token_head),
        .token_length (token_length)
    );

    assign m_axis_tdata = {7'd0, token_length, token_head, match_index};
    assign m_axis_tuser = outcome;

endmodule
